// ===== rtl/rtp_pkg.sv =====
package rtp_pkg;

	localparam int unsigned FULL_SCALE = 1000;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef enum logic [3:0] {
		PH_START  = 4'd0,
		PH_LEAD   = 4'd1,
		PH_SEVDOT = 4'd2,
		PH_SEVDIG = 4'd3,
		PH_SKIP   = 4'd4,
		PH_CLEAD  = 4'd5,
		PH_CDOT   = 4'd6,
		PH_CDIG   = 4'd7,
		PH_TAIL   = 4'd8
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic        minus_seen;
		logic [10:0] severity_acc;
		logic [9:0]  confidence_acc;
		logic [1:0]  digit_pos;
	} parse_state_t;

	localparam parse_state_t PARSE_RESET = '{
		phase:          PH_START,
		minus_seen:     1'b0,
		severity_acc:   11'(FULL_SCALE),
		confidence_acc: 10'd0,
		digit_pos:      2'd0
	};

	// place weight of a fractional digit: FULL_SCALE/10, /100, /1000
	function automatic logic [9:0] weight_of(input logic [1:0] pos);
		logic [9:0] w;
		unique case (pos)
			2'd0:    w = 10'(FULL_SCALE / 10);
			2'd1:    w = 10'(FULL_SCALE / 100);
			2'd2:    w = 10'(FULL_SCALE / 1000);
			default: w = 10'd0;
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/risk_text_parser.sv =====
// Risk string parser, one text byte per transaction.
// Input stream s_*: s_tdata[7:0] is one byte of a string "[-]sev/conf".
// A zero byte closes the string and produces one transaction on m_*;
// every other byte only updates the parse state and produces nothing.
// Output stream m_*: m_tdata[10:0] severity (1000 is zero, 0 is -1.0,
// 2000 is +1.0), m_tdata[20:11] confidence (0 to 1000), upper bits zero.
// Throughput: one byte per cycle while s_tready is high, set by the
// combinational state update that feeds the parse state register.
// The result of an accepted zero byte is registered in the output register,
// or in the skid register while a stalled receiver holds the output register.
// A stalled receiver holds the result in the output register; one more
// result fits in a skid register, and s_tready drops only while that
// skid register is occupied.
// Reset clears the parse state to its start values and empties both
// result registers.
module risk_text_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // [10:0] severity, [20:11] confidence
);

	rtp_pkg::parse_state_t state_q;
	rtp_pkg::parse_state_t state_nxt;
	logic                  emit;
	logic                  accept;
	logic                  result_new;
	logic [20:0]           result;
	logic                  out_valid_q;
	logic [20:0]           out_q;
	logic                  skid_valid_q;
	logic [20:0]           skid_q;

	rtp_step u_step (
		.cur       (state_q),
		.char_code (s_tdata),
		.nxt       (state_nxt),
		.emit      (emit)
	);

	assign s_tready   = !skid_valid_q;
	assign accept     = s_tvalid && s_tready;
	assign result_new = accept && emit;
	assign result     = {state_q.confidence_acc, state_q.severity_acc};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rtp_pkg::PARSE_RESET;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			// advance: skid drains first, input is stalled while it is full
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= result_new;
			end
		end else if (result_new) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_tready) begin
			out_q <= skid_valid_q ? skid_q : result;
		end else if (result_new) begin
			skid_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'd0, out_q};

endmodule

// ===== rtl/rtp_step.sv =====
module rtp_step (
	input  rtp_pkg::parse_state_t cur,
	input  logic [7:0]            char_code,
	output rtp_pkg::parse_state_t nxt,
	output logic                  emit
);

	rtp_pkg::phase_t ph;
	logic            is_num;
	logic [3:0]      digit;
	logic [9:0]      wt;
	logic [13:0]     prod;
	logic            last_digit;
	logic            wt0_zero;

	assign is_num     = (char_code >= rtp_pkg::CH_ZERO) && (char_code <= rtp_pkg::CH_NINE);
	assign digit      = 4'(char_code - rtp_pkg::CH_ZERO);
	assign wt         = rtp_pkg::weight_of(cur.digit_pos);
	assign prod       = 14'(digit) * 14'(wt);
	assign last_digit = (rtp_pkg::weight_of(cur.digit_pos + 2'd1) == 10'd0);
	assign wt0_zero   = (rtp_pkg::weight_of(2'd0) == 10'd0);
	assign emit       = (char_code == rtp_pkg::CH_NUL);

	always_comb begin
		nxt = cur;
		ph  = cur.phase;
		if (emit) begin
			nxt = rtp_pkg::PARSE_RESET;
		end else begin
			// a byte may fall through start, lead and severity phases into skip
			if (ph == rtp_pkg::PH_START) begin
				nxt.phase = rtp_pkg::PH_LEAD;
				if (char_code == rtp_pkg::CH_MINUS) begin
					nxt.minus_seen = 1'b1;
				end else begin
					ph = rtp_pkg::PH_LEAD;
				end
			end
			if (ph == rtp_pkg::PH_LEAD) begin
				if (char_code == rtp_pkg::CH_ONE) begin
					nxt.severity_acc = cur.minus_seen ? 11'd0 : 11'(2 * rtp_pkg::FULL_SCALE);
					nxt.phase = rtp_pkg::PH_SKIP;
				end else if (char_code == rtp_pkg::CH_ZERO) begin
					nxt.severity_acc = 11'(rtp_pkg::FULL_SCALE);
					nxt.phase = rtp_pkg::PH_SEVDOT;
				end else begin
					ph = rtp_pkg::PH_SKIP;
				end
			end else if (ph == rtp_pkg::PH_SEVDOT) begin
				if (char_code == rtp_pkg::CH_DOT) begin
					nxt.digit_pos = 2'd0;
					nxt.phase = wt0_zero ? rtp_pkg::PH_SKIP : rtp_pkg::PH_SEVDIG;
				end else begin
					ph = rtp_pkg::PH_SKIP;
				end
			end else if (ph == rtp_pkg::PH_SEVDIG) begin
				if (is_num && wt != 10'd0) begin
					nxt.severity_acc = cur.minus_seen ? cur.severity_acc - prod[10:0]
						: cur.severity_acc + prod[10:0];
					nxt.digit_pos = cur.digit_pos + 2'd1;
					if (last_digit) begin
						nxt.phase = rtp_pkg::PH_SKIP;
					end
				end else begin
					ph = rtp_pkg::PH_SKIP;
				end
			end
			unique case (ph)
				rtp_pkg::PH_START, rtp_pkg::PH_LEAD, rtp_pkg::PH_SEVDOT,
				rtp_pkg::PH_SEVDIG: begin
				end
				rtp_pkg::PH_SKIP: begin
					nxt.phase = (char_code == rtp_pkg::CH_SLASH) ? rtp_pkg::PH_CLEAD
						: rtp_pkg::PH_SKIP;
				end
				rtp_pkg::PH_CLEAD: begin
					if (char_code == rtp_pkg::CH_ONE) begin
						nxt.confidence_acc = 10'(rtp_pkg::FULL_SCALE);
						nxt.phase = rtp_pkg::PH_TAIL;
					end else if (char_code == rtp_pkg::CH_ZERO) begin
						nxt.confidence_acc = 10'd0;
						nxt.phase = rtp_pkg::PH_CDOT;
					end else begin
						nxt.phase = rtp_pkg::PH_TAIL;
					end
				end
				rtp_pkg::PH_CDOT: begin
					if (char_code == rtp_pkg::CH_DOT) begin
						nxt.digit_pos = 2'd0;
						nxt.phase = wt0_zero ? rtp_pkg::PH_TAIL : rtp_pkg::PH_CDIG;
					end else begin
						nxt.phase = rtp_pkg::PH_TAIL;
					end
				end
				rtp_pkg::PH_CDIG: begin
					if (is_num && wt != 10'd0) begin
						nxt.confidence_acc = cur.confidence_acc + prod[9:0];
						nxt.digit_pos = cur.digit_pos + 2'd1;
						if (last_digit) begin
							nxt.phase = rtp_pkg::PH_TAIL;
						end
					end else begin
						nxt.phase = rtp_pkg::PH_TAIL;
					end
				end
				default: begin
					nxt.phase = rtp_pkg::PH_TAIL;
				end
			endcase
		end
	end

endmodule

// ===== dv/risk_score_checker.sv =====
module risk_score_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // [10:0] severity, [20:11] confidence
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [10:0] severity;
		logic [9:0]  confidence;
	} risk_score_t;

	risk_score_t expected_scores[$];
	risk_score_t oldest_score;

	rtp_pkg::phase_t parse_ph;
	bit              neg_sign;
	int unsigned     sev_acc;
	int unsigned     conf_acc;
	int unsigned     place_wt;

	initial fail_count = 0;

	task automatic report_mismatch(input string msg);
		$display("risk_score_checker @%0t: %s", $time, msg);
		fail_count++;
	endtask

	task automatic rearm_parser();
		parse_ph = rtp_pkg::PH_START;
		neg_sign = 1'b0;
		sev_acc  = rtp_pkg::FULL_SCALE;
		conf_acc = 0;
		place_wt = rtp_pkg::FULL_SCALE / 10;
	endtask

	// Return 1 when the byte has to be taken again in the new phase.
	function automatic bit step_phase(input logic [7:0] c);
		bit          is_digit;
		int unsigned digit_val;
		is_digit  = (c >= rtp_pkg::CH_ZERO) && (c <= rtp_pkg::CH_NINE);
		digit_val = (32'(c) - 32'(rtp_pkg::CH_ZERO)) * place_wt;
		case (parse_ph)
			rtp_pkg::PH_START: begin
				parse_ph = rtp_pkg::PH_LEAD;
				if (c == rtp_pkg::CH_MINUS) begin
					neg_sign = 1'b1;
					return 1'b0;
				end
				return 1'b1;
			end
			rtp_pkg::PH_LEAD: begin
				if (c == rtp_pkg::CH_ONE) begin
					sev_acc  = neg_sign ? 0 : 2 * rtp_pkg::FULL_SCALE;
					parse_ph = rtp_pkg::PH_SKIP;
					return 1'b0;
				end
				if (c == rtp_pkg::CH_ZERO) begin
					sev_acc  = rtp_pkg::FULL_SCALE;
					parse_ph = rtp_pkg::PH_SEVDOT;
					return 1'b0;
				end
				parse_ph = rtp_pkg::PH_SKIP;
				return 1'b1;
			end
			rtp_pkg::PH_SEVDOT: begin
				if (c == rtp_pkg::CH_DOT) begin
					place_wt = rtp_pkg::FULL_SCALE / 10;
					parse_ph = (place_wt != 0) ? rtp_pkg::PH_SEVDIG : rtp_pkg::PH_SKIP;
					return 1'b0;
				end
				parse_ph = rtp_pkg::PH_SKIP;
				return 1'b1;
			end
			rtp_pkg::PH_SEVDIG: begin
				if (is_digit && place_wt != 0) begin
					sev_acc  = neg_sign ? sev_acc - digit_val : sev_acc + digit_val;
					place_wt = place_wt / 10;
					if (place_wt == 0)
						parse_ph = rtp_pkg::PH_SKIP;
					return 1'b0;
				end
				parse_ph = rtp_pkg::PH_SKIP;
				return 1'b1;
			end
			rtp_pkg::PH_SKIP: begin
				if (c == rtp_pkg::CH_SLASH)
					parse_ph = rtp_pkg::PH_CLEAD;
			end
			rtp_pkg::PH_CLEAD: begin
				if (c == rtp_pkg::CH_ONE) begin
					conf_acc = rtp_pkg::FULL_SCALE;
					parse_ph = rtp_pkg::PH_TAIL;
				end else if (c == rtp_pkg::CH_ZERO) begin
					conf_acc = 0;
					parse_ph = rtp_pkg::PH_CDOT;
				end else begin
					parse_ph = rtp_pkg::PH_TAIL;
				end
			end
			rtp_pkg::PH_CDOT: begin
				if (c == rtp_pkg::CH_DOT) begin
					place_wt = rtp_pkg::FULL_SCALE / 10;
					parse_ph = (place_wt != 0) ? rtp_pkg::PH_CDIG : rtp_pkg::PH_TAIL;
				end else begin
					parse_ph = rtp_pkg::PH_TAIL;
				end
			end
			rtp_pkg::PH_CDIG: begin
				if (is_digit && place_wt != 0) begin
					conf_acc = conf_acc + digit_val;
					place_wt = place_wt / 10;
					if (place_wt == 0)
						parse_ph = rtp_pkg::PH_TAIL;
				end else begin
					parse_ph = rtp_pkg::PH_TAIL;
				end
			end
			default: parse_ph = rtp_pkg::PH_TAIL;
		endcase
		return 1'b0;
	endfunction

	task automatic take_char(input logic [7:0] c);
		int k;
		for (k = 0; k < 4; k++) begin
			if (!step_phase(c))
				break;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rearm_parser();
			expected_scores.delete();
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_scores.size() == 0) begin
					report_mismatch($sformatf("result %h with none pending", m_tdata));
				end else begin
					oldest_score = expected_scores.pop_front();
					if (m_tdata[10:0] !== oldest_score.severity)
						report_mismatch($sformatf("severity %0d, predicted %0d",
							m_tdata[10:0], oldest_score.severity));
					if (m_tdata[20:11] !== oldest_score.confidence)
						report_mismatch($sformatf("confidence %0d, predicted %0d",
							m_tdata[20:11], oldest_score.confidence));
				end
			end
			if (s_tvalid && s_tready) begin
				// a NUL byte closes the string: emit and rearm
				if (s_tdata == rtp_pkg::CH_NUL) begin
					expected_scores.push_back('{severity: 11'(sev_acc),
						confidence: 10'(conf_acc)});
					rearm_parser();
				end else begin
					take_char(s_tdata);
				end
			end
			pending <= expected_scores.size();
		end
	end

endmodule

// ===== dv/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_CHARS = 850;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = rtp_pkg::CH_NUL;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;

	int fail_count;
	int pending;
	int cycle_count = 0;
	int chars_sent = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;

	logic [7:0] text_q[$];

	risk_text_parser i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	risk_score_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= rx_idle_pct);

	task automatic send_char(input logic [7:0] c);
		if ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		chars_sent++;
	endtask

	// Send the queued text followed by its NUL terminator.
	task automatic flush_text();
		foreach (text_q[i])
			send_char(text_q[i]);
		send_char(rtp_pkg::CH_NUL);
		text_q.delete();
	endtask

	task automatic queue_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			text_q.push_back(s.getc(i));
	endtask

	task automatic queue_fraction();
		int n;
		n = $urandom_range(5);
		repeat (n) begin
			if ($urandom_range(3) == 0)
				text_q.push_back($urandom_range(1) ? rtp_pkg::CH_NINE : rtp_pkg::CH_ZERO);
			else
				text_q.push_back(8'($urandom_range(rtp_pkg::CH_NINE, rtp_pkg::CH_ZERO)));
		end
	endtask

	task automatic queue_junk(input int max_len);
		repeat ($urandom_range(max_len, 1))
			text_q.push_back(8'($urandom_range(255, 1)));
	endtask

	// Mostly "[-]lead[.digits][junk][/lead[.digits][junk]]", some pure noise.
	task automatic queue_risk_string();
		int roll;
		roll = $urandom_range(9);
		if (roll == 0) begin
			queue_junk(12);
			return;
		end
		if ($urandom_range(1))
			text_q.push_back(rtp_pkg::CH_MINUS);
		roll = $urandom_range(9);
		if (roll < 6) begin
			text_q.push_back(rtp_pkg::CH_ZERO);
			if ($urandom_range(4) != 0)
				text_q.push_back(rtp_pkg::CH_DOT);
			queue_fraction();
		end else if (roll < 8) begin
			text_q.push_back(rtp_pkg::CH_ONE);
		end else begin
			queue_junk(1);
		end
		if ($urandom_range(3) == 0)
			queue_junk(3);
		if ($urandom_range(5) == 0)
			return;
		text_q.push_back(rtp_pkg::CH_SLASH);
		roll = $urandom_range(9);
		if (roll < 6) begin
			text_q.push_back(rtp_pkg::CH_ZERO);
			if ($urandom_range(4) != 0)
				text_q.push_back(rtp_pkg::CH_DOT);
			queue_fraction();
		end else if (roll < 8) begin
			text_q.push_back(rtp_pkg::CH_ONE);
		end else begin
			queue_junk(1);
		end
		if ($urandom_range(2) == 0)
			queue_junk(4);
	endtask

	initial begin
		int phase_end;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 10;
		rx_idle_pct = 78;
		// empty string, both borders, extra digits, missing dot, missing slash
		flush_text();
		queue_text("-1/1");
		flush_text();
		queue_text("-0.9995/0.999");
		flush_text();
		queue_text("0,/x");
		flush_text();
		queue_text("1");
		flush_text();

		for (int ph = 0; ph < 3; ph++) begin
			phase_end = chars_sent + RANDOM_CHARS / 3;
			while (chars_sent < phase_end) begin
				queue_risk_string();
				flush_text();
			end
			if (ph == 0) begin
				tx_idle_pct = 78;
				rx_idle_pct = 10;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
